[design/bfba_pkg.sv]
`default_nettype none
package bfba_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BUFFER_LENGTH = 2'd1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_OFFSET    = 2'd1;
    localparam logic [1:0] STATUS_WIDTH     = 2'd2;
    localparam logic [1:0] STATUS_TOO_LARGE = 2'd3;

    localparam logic ACTION_READ  = 1'b0;
    localparam logic ACTION_WRITE = 1'b1;

    localparam logic [3:0] RESET_DEFAULT_WIDTH = 4'd8;
    localparam logic [3:0] MAX_WIDTH           = 4'd8;

    typedef struct packed {
        logic        action;
        logic [15:0] start_bit;
        logic [3:0]  field_width;
        logic [7:0]  write_value;
    } bfba_in_t;

    typedef struct packed {
        logic [7:0] read_value;
        logic [1:0] status;
    } bfba_out_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_CALC,
        ST_WR0,
        ST_WR1,
        ST_DONE
    } bfba_state_t;

    // ones in the low w bits, w in 1..8
    function automatic logic [7:0] width_mask(input logic [3:0] w);
        logic [3:0] sh;
        sh = MAX_WIDTH - w;
        return 8'hff >> sh[2:0];
    endfunction

endpackage
`default_nettype wire

[design/bfba_ram.sv]
`default_nettype none
module bfba_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                                       aclk,
    input  wire logic                                       we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[design/bfba_field_unit.sv]
`default_nettype none
module bfba_field_unit (
    input  wire logic [15:0] window,
    input  wire logic [2:0]  pos,
    input  wire logic [3:0]  width,
    input  wire logic [7:0]  value,
    output logic      [7:0]  read_byte,
    output logic      [15:0] new_window
);
    import bfba_pkg::*;

    logic [4:0]  shift;
    logic [7:0]  mask8;
    logic [15:0] window_sh;
    logic [15:0] mask16;
    logic [15:0] value16;

    // field lsb sits at window bit 16 - pos - width
    always_comb begin
        shift      = 5'd16 - {2'b00, pos} - {1'b0, width};
        mask8      = width_mask(width);
        window_sh  = window >> shift;
        read_byte  = window_sh[7:0] & mask8;
        mask16     = {8'h00, mask8} << shift;
        value16    = {8'h00, value & mask8} << shift;
        new_window = (window & ~mask16) | value16;
    end

endmodule
`default_nettype wire

[design/bit_field_buffer_access_core.sv]
`default_nettype none
// Bit-addressed field store, msb of each byte first.
// Input channel s_*: one word per access (read or write of a 1..8 bit field
// at any bit offset, width 0 picks the default width). Result channel m_*:
// one word per access with the right-aligned read value and a status code.
// Config channel cfg_*: index 0 sets the default width (values outside 1..8
// are dropped), index 1 sets the number of bytes in use; cfg_ready is always
// high, writes are expected only while the core is idle.
// Sequencing: the byte store is a single-port-per-direction RAM with
// registered read, and one sequencer steps a shared bit-field shifter over
// it. An item that fails a check goes straight to DONE; a read steps RD0,
// RD1, CALC; a write adds WR0 and, when it straddles two bytes, WR1.
// The result shows on m_valid in the same cycle that s_ready returns.
// Reset: after aresetn the core clears every RAM byte, one per cycle, so
// s_ready stays low until all are clear; config writes are taken then.
// Stall: a result waits in the output register while m_ready is low; the
// core still accepts the next item and holds its result until the output
// register frees up.
module bit_field_buffer_access_core #(
    parameter int unsigned BUFFER_BYTES = 4096
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire bfba_pkg::bfba_in_t                    s_data,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output bfba_pkg::bfba_out_t                        m_data,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [bfba_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [bfba_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import bfba_pkg::*;

    localparam int unsigned AW = BUFFER_BYTES > 1 ? $clog2(BUFFER_BYTES) : 1;
    localparam logic [13:0] STORE_BYTES = 14'(BUFFER_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(BUFFER_BYTES - 1);

    bfba_state_t state_reg, state_next;

    logic [3:0]    dflt_width_reg;
    logic [12:0]   length_reg;
    logic [AW-1:0] clr_cnt_reg;

    logic          action_reg;
    logic [2:0]    pos_reg;
    logic [3:0]    width_reg;
    logic [7:0]    value_reg;
    logic [AW-1:0] addr0_reg;
    logic          two_reg;
    logic [1:0]    status_reg;
    logic [7:0]    b0_reg;
    logic [7:0]    result_reg;
    logic [7:0]    wr0_reg;
    logic [7:0]    wr1_reg;

    logic          m_valid_reg;
    bfba_out_t     out_reg;

    logic          accept;
    logic          load_out;
    logic [13:0]   limit;
    logic [12:0]   byte_idx;
    logic [13:0]   next_idx;
    logic [3:0]    eff_width;
    logic [4:0]    end_bit;
    logic [1:0]    status_in;
    logic          two_in;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic [AW-1:0] addr1;

    logic [15:0]   window;
    logic [7:0]    fu_read;
    logic [15:0]   fu_window;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign load_out  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign addr1     = addr0_reg + AW'(1);

    // checks on the incoming word, in priority order
    always_comb begin
        limit     = ({1'b0, length_reg} > STORE_BYTES) ? STORE_BYTES : {1'b0, length_reg};
        byte_idx  = s_data.start_bit[15:3];
        next_idx  = {1'b0, byte_idx} + 14'd1;
        eff_width = (s_data.field_width == 4'd0) ? dflt_width_reg : s_data.field_width;
        end_bit   = {2'b00, s_data.start_bit[2:0]} + {1'b0, eff_width};
        two_in    = (end_bit > 5'd8) && (next_idx < limit);
        priority if ({1'b0, byte_idx} >= limit) begin
            status_in = STATUS_OFFSET;
        end else if (eff_width == 4'd0 || eff_width > MAX_WIDTH) begin
            status_in = STATUS_WIDTH;
        end else if (s_data.action == ACTION_WRITE &&
                     (s_data.write_value & ~width_mask(eff_width)) != 8'h00) begin
            status_in = STATUS_TOO_LARGE;
        end else begin
            status_in = STATUS_OK;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_cnt_reg == LAST_ADDR) state_next = ST_IDLE;
            ST_IDLE: begin
                if (accept) begin
                    state_next = (status_in == STATUS_OK) ? ST_RD0 : ST_DONE;
                end
            end
            ST_RD0:  state_next = ST_RD1;
            ST_RD1:  state_next = ST_CALC;
            ST_CALC: state_next = (action_reg == ACTION_WRITE) ? ST_WR0 : ST_DONE;
            ST_WR0:  state_next = two_reg ? ST_WR1 : ST_DONE;
            ST_WR1:  state_next = ST_DONE;
            ST_DONE: if (load_out) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = addr0_reg;
        ram_wdata = wr0_reg;
        ram_raddr = addr0_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = 8'h00;
            end
            ST_RD1:  ram_raddr = addr1;
            ST_WR0:  ram_we = 1'b1;
            ST_WR1: begin
                ram_we    = 1'b1;
                ram_waddr = addr1;
                ram_wdata = wr1_reg;
            end
            default: ram_raddr = addr0_reg;
        endcase
    end

    // second byte reads as zero when unused or past the bytes in use
    assign window = {b0_reg, two_reg ? ram_rdata : 8'h00};

    bfba_field_unit u_field (
        .window     (window),
        .pos        (pos_reg),
        .width      (width_reg),
        .value      (value_reg),
        .read_byte  (fu_read),
        .new_window (fu_window)
    );

    bfba_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            dflt_width_reg <= RESET_DEFAULT_WIDTH;
            length_reg     <= 13'd4096;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_DEFAULT_WIDTH) begin
                    if (cfg_data[3:0] != 4'd0 && cfg_data[3:0] <= MAX_WIDTH) begin
                        dflt_width_reg <= cfg_data[3:0];
                    end
                end else if (cfg_index == REG_BUFFER_LENGTH) begin
                    length_reg <= cfg_data[12:0];
                end
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            action_reg <= s_data.action;
            pos_reg    <= s_data.start_bit[2:0];
            width_reg  <= eff_width;
            value_reg  <= s_data.write_value;
            addr0_reg  <= byte_idx[AW-1:0];
            two_reg    <= two_in;
            status_reg <= status_in;
            result_reg <= 8'h00;
        end
        if (state_reg == ST_RD1) begin
            b0_reg <= ram_rdata;
        end
        if (state_reg == ST_CALC) begin
            result_reg <= (action_reg == ACTION_WRITE) ? 8'h00 : fu_read;
            wr0_reg    <= fu_window[15:8];
            wr1_reg    <= fu_window[7:0];
        end
        if (load_out) begin
            out_reg.read_value <= result_reg;
            out_reg.status     <= status_reg;
        end
    end

`ifndef SYNTHESIS
    a_rd_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD0) |-> (status_reg == STATUS_OK))
        else $error("field access started on a failed check");

    a_wr1_straddle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WR1) |-> (two_reg && action_reg == ACTION_WRITE))
        else $error("second byte written without a straddling write");

    a_out_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside the done step");
`endif

endmodule
`default_nettype wire
